[rtl/wrp_pkg.sv]
// wrp_pkg: shared types and constants for the wav riff chunk parser
// used by wrp_ctrl, wrp_datapath and wav_riff_chunk_parser
`default_nettype none
package wrp_pkg;

    typedef enum logic [6:0] {
        PH_PRE  = 7'b0000001,
        PH_HDR  = 7'b0000010,
        PH_FMT  = 7'b0000100,
        PH_SKIP = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_DIV  = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_SMP = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_WAVE = 3'd1;
    localparam logic [2:0] ST_NOT_PCM  = 3'd2;
    localparam logic [2:0] ST_NOT_16   = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_NO_FMT   = 3'd5;
    localparam logic [2:0] ST_SHORT    = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] PCM_CODE = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;
    localparam int          DIV_STEPS = 32;

    typedef struct packed {
        logic       take;
        logic       sof;
        t_phase     phase;
        logic       div_start;
        logic       div_finish;
        logic       emit;
        logic [1:0] kind;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic pre_end;
        logic pre_ok;
        logic hdr_end;
        logic tag_fmt;
        logic tag_data;
        logic fmt_ok;
        logic len_zero;
        logic fmt_end;
        logic code_pcm;
        logic bits16;
        logic len_gt16;
        logic skip_end;
        logic data_odd;
        logic smp_last;
        logic div_busy;
        logic quot_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[rtl/wrp_datapath.sv]
// wrp_datapath: field capture, chunk counters, frame divider and result register
// depends on wrp_pkg, driven by wrp_ctrl commands
`default_nettype none
module wrp_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_byte,
    input  wire wrp_pkg::t_cmd i_cmd,
    input  wire logic          i_out_ready,
    output wrp_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic [1:0]         o_out_kind,
    output logic [119:0]       o_out_data,
    output logic               o_out_last
);
    import wrp_pkg::*;

    logic [3:0]  r_idx,  n_idx;
    logic [31:0] r_tag,  n_tag;
    logic [31:0] r_len,  n_len;
    logic [15:0] r_code, n_code;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_fmt_seen, n_fmt_seen;
    logic [7:0]  r_low,  n_low;
    logic [15:0] r_chpos, n_chpos;
    logic [30:0] r_frm,  n_frm;
    logic [31:0] r_dq;
    logic [16:0] r_rem;
    logic [16:0] r_dvs;
    logic [5:0]  r_cnt;
    logic [17:0] w_trial;
    logic        w_ge;

    logic        r_ov;
    logic [1:0]  r_okind;
    logic [119:0] r_odata, n_odata;
    logic        r_olast, n_olast;

    logic [3:0]  e_idx;
    logic [31:0] e_tag, e_len, w_tag_base, w_len_base;
    logic [1:0]  w_pos;
    logic        w_last_ch;

    always_comb begin
        e_idx = i_cmd.sof ? 4'd0 : r_idx;
        e_tag = i_cmd.sof ? 32'd0 : r_tag;
        e_len = i_cmd.sof ? 32'd0 : r_len;
        w_pos = e_idx[1:0];
        w_tag_base = (i_cmd.phase == PH_HDR && e_idx == 4'd0) ? 32'd0 : e_tag;
        w_len_base = (i_cmd.phase == PH_HDR && e_idx == 4'd4) ? 32'd0 : e_len;
        n_tag = w_tag_base;
        n_len = w_len_base;
        if ((i_cmd.phase == PH_PRE || i_cmd.phase == PH_HDR) && e_idx < 4'd4) begin
            n_tag[8*w_pos +: 8] = i_byte;
        end
        if ((i_cmd.phase == PH_PRE && e_idx >= 4'd8) ||
            (i_cmd.phase == PH_HDR && e_idx >= 4'd4)) begin
            n_len[8*w_pos +: 8] = i_byte;
        end
        n_bits = r_bits;
        if (i_cmd.phase == PH_FMT && e_idx >= 4'd14) begin
            n_bits[8*e_idx[0] +: 8] = i_byte;
        end
        w_last_ch = (r_chpos == r_chan - 16'd1);
    end

    always_comb begin
        o_stat.pre_end  = (e_idx == 4'd11);
        o_stat.pre_ok   = (n_tag == TAG_RIFF) && (n_len == TAG_WAVE);
        o_stat.hdr_end  = (e_idx == 4'd7);
        o_stat.tag_fmt  = (r_tag == TAG_FMT);
        o_stat.tag_data = (r_tag == TAG_DATA);
        o_stat.fmt_ok   = r_fmt_seen && (r_chan != 16'd0);
        o_stat.len_zero = (n_len == 32'd0);
        o_stat.fmt_end  = (e_idx == 4'd15);
        o_stat.code_pcm = (r_code == PCM_CODE);
        o_stat.bits16   = (n_bits == PCM_BITS);
        o_stat.len_gt16 = (r_len > FMT_BODY_LEN);
        o_stat.skip_end = (r_len[31:1] == 31'd0);
        o_stat.data_odd = r_idx[0];
        o_stat.smp_last = (r_frm == 31'd1) && w_last_ch;
        o_stat.div_busy = (r_cnt != 6'd0);
        o_stat.quot_zero = (r_dq == 32'd0);
        o_stat.out_free = !r_ov || i_out_ready;
    end

    always_comb begin
        n_idx = r_idx;
        n_code = r_code;
        n_chan = r_chan;
        n_rate = r_rate;
        n_fmt_seen = r_fmt_seen;
        n_low = r_low;
        n_chpos = r_chpos;
        n_frm = r_frm;
        if (i_cmd.take) begin
            if (i_cmd.sof) begin
                n_fmt_seen = 1'b0;
                n_chan = 16'd0;
            end
            unique case (i_cmd.phase)
                PH_PRE: begin
                    n_idx = (e_idx == 4'd11) ? 4'd0 : e_idx + 4'd1;
                end
                PH_HDR: begin
                    n_idx = (e_idx == 4'd7) ? 4'd0 : e_idx + 4'd1;
                    if (e_idx == 4'd7 && r_tag == TAG_FMT) begin
                        n_code = 16'd0;
                        n_chan = 16'd0;
                        n_rate = 32'd0;
                    end
                end
                PH_FMT: begin
                    n_idx = e_idx + 4'd1;
                    if (e_idx < 4'd2) begin
                        n_code[8*e_idx[0] +: 8] = i_byte;
                    end else if (e_idx < 4'd4) begin
                        n_chan[8*e_idx[0] +: 8] = i_byte;
                    end else if (e_idx < 4'd8) begin
                        n_rate[8*e_idx[1:0] +: 8] = i_byte;
                    end
                    if (e_idx == 4'd15) begin
                        n_fmt_seen = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_idx = 4'd0;
                end
                PH_DATA: begin
                    n_idx = {3'd0, ~r_idx[0]};
                    if (!r_idx[0]) begin
                        n_low = i_byte;
                    end else if (w_last_ch) begin
                        n_chpos = 16'd0;
                        n_frm = r_frm - 31'd1;
                    end else begin
                        n_chpos = r_chpos + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_finish) begin
            n_frm = r_dq[30:0];
            n_chpos = 16'd0;
            n_idx = 4'd0;
        end
    end

    // length register: header capture, fmt remainder, skip countdown
    logic [31:0] w_len_next;
    always_comb begin
        w_len_next = r_len;
        if (i_cmd.take) begin
            unique case (i_cmd.phase) inside
                PH_PRE, PH_HDR: w_len_next = n_len;
                PH_FMT: begin
                    if (e_idx == 4'd15 && r_len > FMT_BODY_LEN) begin
                        w_len_next = r_len - FMT_BODY_LEN;
                    end
                end
                PH_SKIP: begin
                    if (r_len != 32'd0) begin
                        w_len_next = r_len - 32'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_tag <= '0;
            r_len <= '0;
            r_code <= '0;
            r_chan <= '0;
            r_rate <= '0;
            r_bits <= '0;
            r_fmt_seen <= 1'b0;
            r_low <= '0;
            r_chpos <= '0;
            r_frm <= '0;
            r_cnt <= '0;
        end else begin
            r_idx <= n_idx;
            r_code <= n_code;
            r_chan <= n_chan;
            r_rate <= n_rate;
            r_fmt_seen <= n_fmt_seen;
            r_low <= n_low;
            r_chpos <= n_chpos;
            r_frm <= n_frm;
            r_len <= w_len_next;
            if (i_cmd.take && (i_cmd.phase == PH_PRE || i_cmd.phase == PH_HDR)) begin
                r_tag <= n_tag;
            end
            if (i_cmd.take && i_cmd.phase == PH_HDR && e_idx == 4'd7 && r_tag == TAG_FMT) begin
                r_bits <= 16'd0;
            end else if (i_cmd.take && i_cmd.phase == PH_FMT) begin
                r_bits <= n_bits;
            end
            if (i_cmd.div_start) begin
                r_cnt <= 6'(DIV_STEPS);
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    assign w_trial = {r_rem, r_dq[31]};
    assign w_ge = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq <= n_len;
            r_rem <= '0;
            r_dvs <= {r_chan, 1'b0};
        end else if (r_cnt != 6'd0) begin
            r_rem <= w_ge ? 17'(w_trial - {1'b0, r_dvs}) : w_trial[16:0];
            r_dq <= {r_dq[30:0], w_ge};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_comb begin
        n_odata = '0;
        n_olast = 1'b0;
        n_odata[2:0] = i_cmd.status;
        case (i_cmd.kind)
            KIND_HDR: begin
                n_odata[34:3] = r_rate;
                n_odata[50:35] = r_chan;
                n_odata[81:51] = r_dq[30:0];
            end
            KIND_SMP: begin
                n_odata[97:82] = {i_byte, r_low};
                n_odata[113:98] = r_chpos;
                n_olast = (r_frm == 31'd1) && w_last_ch;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind <= i_cmd.kind;
            r_odata <= n_odata;
            r_olast <= n_olast;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_kind = r_okind;
    assign o_out_data = r_odata;
    assign o_out_last = r_olast;

endmodule
`default_nettype wire

[rtl/wrp_ctrl.sv]
// wrp_ctrl: parse phase state machine, strict mode register and handshakes
// depends on wrp_pkg, steers wrp_datapath through t_cmd
`default_nettype none
module wrp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_sof,
    input  wire logic           i_eos,
    output logic                o_ready,
    input  wire logic           i_cfg_valid,
    input  wire logic           i_cfg_data,
    output logic                o_cfg_ready,
    input  wire wrp_pkg::t_stat i_stat,
    output wrp_pkg::t_cmd       o_cmd
);
    import wrp_pkg::*;

    t_phase r_phase, n_phase, w_ph;
    logic   r_eos, r_strict;
    logic   w_take;

    assign o_ready = (r_phase != PH_DIV) && i_stat.out_free;
    assign o_cfg_ready = 1'b1;
    assign w_take = i_valid && o_ready;
    assign w_ph = (w_take && i_sof) ? PH_PRE : r_phase;

    always_comb begin
        n_phase = w_ph;
        o_cmd = '0;
        o_cmd.take = w_take;
        o_cmd.sof = w_take && i_sof;
        o_cmd.phase = w_ph;
        o_cmd.kind = KIND_ERR;
        o_cmd.status = ST_OK;
        if (w_take) begin
            unique case (w_ph)
                PH_PRE: begin
                    if (i_stat.pre_end) begin
                        if (i_stat.pre_ok) begin
                            n_phase = PH_HDR;
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.status = ST_NOT_WAVE;
                            n_phase = PH_DONE;
                        end
                    end
                end
                PH_HDR: begin
                    if (i_stat.hdr_end) begin
                        if (i_stat.tag_fmt) begin
                            n_phase = PH_FMT;
                        end else if (i_stat.tag_data) begin
                            if (i_stat.fmt_ok) begin
                                o_cmd.div_start = 1'b1;
                                n_phase = PH_DIV;
                            end else begin
                                o_cmd.emit = 1'b1;
                                o_cmd.status = ST_NO_FMT;
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_phase = i_stat.len_zero ? PH_HDR : PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    if (i_stat.fmt_end) begin
                        if (r_strict && !i_stat.code_pcm) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.status = ST_NOT_PCM;
                            n_phase = PH_DONE;
                        end else if (r_strict && !i_stat.bits16) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.status = ST_NOT_16;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = i_stat.len_gt16 ? PH_SKIP : PH_HDR;
                        end
                    end
                end
                PH_SKIP: begin
                    if (i_stat.skip_end) begin
                        n_phase = PH_HDR;
                    end
                end
                PH_DATA: begin
                    if (i_stat.data_odd) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_SMP;
                        if (i_stat.smp_last) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (i_eos && n_phase != PH_DONE && n_phase != PH_DIV) begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_ERR;
                o_cmd.status = (n_phase == PH_DATA) ? ST_SHORT : ST_TRUNC;
                n_phase = PH_DONE;
            end
        end else if (r_phase == PH_DIV && !i_stat.div_busy && i_stat.out_free) begin
            o_cmd.div_finish = 1'b1;
            o_cmd.emit = 1'b1;
            if (i_stat.quot_zero) begin
                o_cmd.kind = KIND_HDR;
                n_phase = PH_DONE;
            end else if (r_eos) begin
                o_cmd.status = ST_SHORT;
                n_phase = PH_DONE;
            end else begin
                o_cmd.kind = KIND_HDR;
                n_phase = PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_eos <= 1'b0;
            r_strict <= 1'b1;
        end else begin
            r_phase <= n_phase;
            if (o_cmd.div_start) begin
                r_eos <= i_eos;
            end
            if (i_cfg_valid) begin
                r_strict <= i_cfg_data;
            end
        end
    end

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free) else $error("result written while occupied");
    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_phase == PH_DIV) else $error("divider start lost");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(w_take && i_sof)) |=> r_phase == PH_DONE)
        else $error("left done without restart");
    a_div_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_finish |-> (o_cmd.emit && !w_take)) else $error("divide finish mismatch");

endmodule
`default_nettype wire

[rtl/wav_riff_chunk_parser.sv]
// wav_riff_chunk_parser: byte stream wav parser, header, samples and errors
// results: registered, out in the cycle after the byte; the header result waits on the divider
// throughput: one byte per cycle while the result register is free; input stalls after the data
// chunk header while the serial divider forms the frame count, one bit per cycle
// reset: synchronous active low, parser back to preamble, strict mode on
// depends on wrp_pkg, wrp_ctrl, wrp_datapath
`default_nettype none
module wav_riff_chunk_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // data_byte
    input  wire logic         i_s_axis_tuser,   // start_of_file
    input  wire logic         i_s_axis_tlast,   // end_of_stream
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // status, sample_rate, channel_count, frame_count, sample_value, channel_index
    output logic [119:0]      o_m_axis_tdata,
    output logic [1:0]        o_m_axis_tuser,   // result_kind
    output logic              o_m_axis_tlast,   // last_sample
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_data        // strict_format
);
    import wrp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_sof       (i_s_axis_tuser),
        .i_eos       (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    wrp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

[tb/sv/tb_wav_riff_chunk_parser.sv]
// testbench for wav_riff_chunk_parser: byte-level wav files in, header, sample and
// error words out, checked against a behavioral parser model kept in this file
// depends on wrp_pkg and the wav_riff_chunk_parser rtl
`timescale 1ns / 1ps
module tb_wav_riff_chunk_parser;
    import wrp_pkg::*;

    typedef enum logic [2:0] {
        P_PRE, P_HDR, P_FMT, P_SKIP, P_DATA, P_DONE
    } t_wphase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] rate;
        logic [15:0] chans;
        logic [30:0] frames;
        logic [15:0] smp;
        logic [15:0] chan_idx;
        logic        last;
    } t_wav_out;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        logic       eos;
    } t_wav_byte;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [7:0] s_data = 0;
    logic s_user = 0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [119:0] m_data;
    logic [1:0] m_user;
    logic m_last;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic cfg_data = 0;

    wav_riff_chunk_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user), .o_m_axis_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // parser model state
    logic        strict_q;
    t_wphase     ph;
    logic [31:0] fcnt, tag, clen, rate_q, left;
    logic [15:0] fcode, chans_q, bits_q, chpos;
    logic        fmt_q;
    logic [7:0]  lo_q;

    t_wav_byte pending_bytes[$];
    t_wav_out  expected_words[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    task automatic clear_model();
        ph = P_PRE; fcnt = 0; tag = 0; clen = 0; fcode = 0; chans_q = 0;
        rate_q = 0; bits_q = 0; fmt_q = 0; left = 0; lo_q = 0; chpos = 0;
    endtask

    function automatic t_wav_out err_word(logic [2:0] st);
        t_wav_out o;
        o = '0; o.kind = KIND_ERR; o.status = st;
        return o;
    endfunction

    task automatic parse_byte(t_wav_byte x);
        t_wav_out o;
        logic got;
        logic [31:0] idx, fr;
        o = '0; got = 0;
        if (x.sof) clear_model();
        idx = fcnt;
        case (ph)
            P_PRE: begin
                if (idx < 4) tag |= 32'(x.b) << (8 * idx);
                else if (idx >= 8 && idx < 12) clen |= 32'(x.b) << (8 * (idx - 8));
                fcnt = idx + 1;
                if (idx >= 11) begin
                    if (tag != TAG_RIFF || clen != TAG_WAVE) begin
                        o = err_word(ST_NOT_WAVE); got = 1; ph = P_DONE;
                    end else begin
                        ph = P_HDR; fcnt = 0;
                    end
                end
            end
            P_HDR: begin
                if (idx == 0) tag = 0;
                if (idx == 4) clen = 0;
                if (idx < 4) tag |= 32'(x.b) << (8 * idx);
                else clen |= 32'(x.b) << (8 * ((idx - 4) & 3));
                fcnt = idx + 1;
                if (idx >= 7) begin
                    fcnt = 0;
                    if (tag == TAG_FMT) begin
                        ph = P_FMT; fcode = 0; chans_q = 0; rate_q = 0; bits_q = 0;
                    end else if (tag == TAG_DATA) begin
                        if (!fmt_q || chans_q == 0) begin
                            o = err_word(ST_NO_FMT); got = 1; ph = P_DONE;
                        end else begin
                            fr = clen / ({16'd0, chans_q} * 2);
                            left = fr * chans_q;
                            chpos = 0;
                            o.kind = KIND_HDR; o.rate = rate_q; o.chans = chans_q;
                            o.frames = fr[30:0]; got = 1;
                            ph = (left != 0) ? P_DATA : P_DONE;
                        end
                    end else begin
                        ph = (clen != 0) ? P_SKIP : P_HDR;
                    end
                end
            end
            P_FMT: begin
                if (idx < 2) fcode |= 16'(x.b) << (8 * idx);
                else if (idx < 4) chans_q |= 16'(x.b) << (8 * (idx - 2));
                else if (idx < 8) rate_q |= 32'(x.b) << (8 * (idx - 4));
                else if (idx >= 14 && idx < 16) bits_q |= 16'(x.b) << (8 * (idx - 14));
                fcnt = idx + 1;
                if (idx >= 15) begin
                    fcnt = 0; fmt_q = 1;
                    if (strict_q && fcode != PCM_CODE) begin
                        o = err_word(ST_NOT_PCM); got = 1; ph = P_DONE;
                    end else if (strict_q && bits_q != PCM_BITS) begin
                        o = err_word(ST_NOT_16); got = 1; ph = P_DONE;
                    end else if (clen > FMT_BODY_LEN) begin
                        clen -= FMT_BODY_LEN; ph = P_SKIP;
                    end else ph = P_HDR;
                end
            end
            P_SKIP: begin
                if (clen != 0) clen--;
                if (clen == 0) begin ph = P_HDR; fcnt = 0; end
            end
            P_DATA: begin
                if (!idx[0]) lo_q = x.b;
                else begin
                    o.kind = KIND_SMP; o.smp = {x.b, lo_q}; o.chan_idx = chpos;
                    if (left != 0) left--;
                    o.last = (left == 0); got = 1;
                    chpos++;
                    if (chpos >= chans_q) chpos = 0;
                    if (left == 0) ph = P_DONE;
                end
                fcnt = {31'd0, ~idx[0]};
            end
            default: ;
        endcase
        if (x.eos && ph != P_DONE) begin
            o = err_word(ph == P_DATA ? ST_SHORT : ST_TRUNC); got = 1; ph = P_DONE;
        end
        if (got) expected_words.push_back(o);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] exp_v);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got_v, exp_v, cycles);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready) parse_byte({s_data, s_user, s_last});
            if ((!s_valid || s_ready)) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_wav_byte x;
                    x = pending_bytes.pop_front();
                    s_valid <= 1; s_data <= x.b; s_user <= x.sof; s_last <= x.eos;
                end else s_valid <= 0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", {m_user, m_data[2:0]}, 0);
            end else begin
                t_wav_out e;
                e = expected_words.pop_front();
                if (m_user != e.kind) report_mismatch("kind", m_user, e.kind);
                if (m_data[2:0] != e.status) report_mismatch("status", m_data[2:0], e.status);
                if (m_data[34:3] != e.rate) report_mismatch("rate", m_data[34:3], e.rate);
                if (m_data[50:35] != e.chans) report_mismatch("chans", m_data[50:35], e.chans);
                if (m_data[81:51] != e.frames)
                    report_mismatch("frames", m_data[81:51], e.frames);
                if (m_data[97:82] != e.smp) report_mismatch("sample", m_data[97:82], e.smp);
                if (m_data[113:98] != e.chan_idx)
                    report_mismatch("chan_idx", m_data[113:98], e.chan_idx);
                if (m_data[119:114] != 0) report_mismatch("pad", m_data[119:114], 0);
                if (m_last != e.last) report_mismatch("last", m_last, e.last);
            end
        end
        if (cycles > 2000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic put(logic [7:0] b, logic sof = 0, logic eos = 0);
        pending_bytes.push_back({b, sof, eos});
    endtask

    task automatic put32(logic [31:0] v);
        for (int i = 0; i < 4; i++) put(v[8*i +: 8]);
    endtask

    task automatic put16(logic [15:0] v);
        put(v[7:0]); put(v[15:8]);
    endtask

    // one file; bad_kind: 0 good, 1 bad preamble, 2 data before fmt, 3 truncated
    task automatic build_file(int bad_kind, logic [15:0] code, logic [15:0] nch,
                              logic [15:0] bits, int fmt_len, int junk_len, int data_len,
                              int cut);
        int n0, total;
        n0 = pending_bytes.size();
        put(8'h52, 1'b1); put(8'h49); put(8'h46);
        put(bad_kind == 1 ? 8'h58 : 8'h46);
        put32($urandom); put32(TAG_WAVE);
        if (junk_len >= 0) begin
            put32(32'h4b4e_554a); put32(junk_len);
            for (int i = 0; i < junk_len; i++) put(8'($urandom));
        end
        if (bad_kind != 2) begin
            put32(TAG_FMT); put32(fmt_len);
            put16(code); put16(nch); put32($urandom_range(96000, 8000));
            put32($urandom); put16(16'($urandom)); put16(bits);
            for (int i = 16; i < fmt_len; i++) put(8'($urandom));
        end
        put32(TAG_DATA); put32(data_len);
        for (int i = 0; i < data_len; i++) put(8'($urandom));
        total = pending_bytes.size() - n0;
        if (bad_kind == 3 && cut > 0 && cut < total) begin
            while (pending_bytes.size() > n0 + cut) void'(pending_bytes.pop_back());
        end
        if (bad_kind == 3) pending_bytes[$].eos = 1;
    endtask

    task automatic wait_drain();
        while (pending_bytes.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_strict(logic v);
        @(posedge i_clk);
        cfg_valid <= 1; cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        strict_q = v;
        cfg_valid <= 0;
    endtask

    initial begin
        int ph_idle[4] = '{0, 53, 0, 8};
        int ph_stall[4] = '{0, 0, 53, 8};
        int nbytes;
        strict_q = 1;
        clear_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: truncated preamble, bad preamble, short fmt, data before fmt, strict rejects, zero channels
        build_file(0, 1, 1, 16, 16, -1, 8, 0);
        put(8'h00, 1'b1); put(8'h80); put(8'hff); put(8'hff, 1'b0, 1'b1);
        build_file(1, 1, 2, 16, 16, -1, 4, 0);
        build_file(0, 1, 2, 16, 12, 0, 3, 0);
        build_file(2, 1, 1, 16, 16, 3, 4, 0);
        build_file(0, 3, 1, 16, 16, -1, 4, 0);
        build_file(0, 1, 1, 8, 18, -1, 4, 0);
        build_file(0, 1, 0, 16, 16, -1, 4, 0);
        wait_drain();
        write_strict(0);
        build_file(0, 16'hfffe, 3, 24, 20, 1, 13, 0);
        build_file(0, 1, 16'hffff, 16'hffff, 16, -1, 2, 0);
        build_file(3, 1, 2, 16, 16, -1, 8, 46);
        build_file(3, 1, 2, 16, 16, -1, 8, 30);
        wait_drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct = ph_idle[p]; stall_pct = ph_stall[p];
            write_strict(p[0]);
            nbytes = 0;
            while (nbytes < 25) begin
                int k, n0;
                n0 = pending_bytes.size();
                k = $urandom_range(9);
                if (k < 6)
                    build_file(0, 16'($urandom_range(3) == 0 ? $urandom : 1),
                               16'($urandom_range(4)),
                               16'($urandom_range(3) == 0 ? $urandom : 16),
                               $urandom_range(20, 12), $urandom_range(3) - 1,
                               $urandom_range(14), 0);
                else if (k < 8)
                    build_file(3, 1, 16'($urandom_range(1, 3)), 16, 16, -1,
                               $urandom_range(10), $urandom_range(1, 50));
                else if (k < 9) build_file($urandom_range(1, 2), 1, 1, 16, 16, -1, 4, 0);
                else for (int i = 0; i < 6; i++) put(8'($urandom), $urandom_range(5) == 0,
                                                    $urandom_range(9) == 0);
                nbytes += pending_bytes.size() - n0;
                wait_drain();
            end
        end
        idle_pct = 0; stall_pct = 0;
        wait_drain();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
